FILE: src/ailr_pkg.sv
`timescale 1ns / 1ps

package ailr_pkg;

   // store size and derived widths
   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);
   localparam int POS_W  = 7;
   localparam int WORD_W = 32;
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   typedef enum logic [2:0] {
      OP_PUSH_BACK  = 3'd0,
      OP_PUSH_FRONT = 3'd1,
      OP_POP_BACK   = 3'd2,
      OP_POP_FRONT  = 3'd3,
      OP_INSERT     = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      STAT_DONE   = 2'd0,
      STAT_FULL   = 2'd1,
      STAT_EMPTY  = 2'd2,
      STAT_BADPOS = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_POP_RD,
      S_POP_CAP,
      S_SHIFT_RD,
      S_SHIFT_WR,
      S_PLACE,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic [2:0]              op;
      logic [POS_W-1:0]        position;
      logic signed [WORD_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] popped_value;
      logic [1:0]              status;
      logic [CNT_W-1:0]        entry_count;
      logic                    is_empty;
   } rsp_type;

   // sequencer to store
   typedef struct packed {
      logic              we;
      logic [ADDR_W-1:0] waddr;
      logic [WORD_W-1:0] wdata;
      logic [ADDR_W-1:0] raddr;
   } mem_cmd_type;

endpackage

FILE: src/array_list_insert_remove_core.sv
`timescale 1ns / 1ps

// ordered list of signed 32-bit words in a 64-entry store with an entry count.
// a request is taken when start is high and busy is low; busy then stays high
// until the request is finished. each request gives exactly one response,
// shown on rsp_data for a single cycle with rsp_valid high; there is no way to
// stall it, so the receiver must take it in that cycle. the response strobe
// comes in the first cycle that busy is low, and a new request can be taken
// in that same cycle. a refused or unknown op goes straight to finish; push back
// places the value; pop back reads and captures the last entry; push front and
// insert move each entry from position on up one place, then place the value;
// pop front captures the first entry, then moves each later entry down one place.
// each entry moved is read in one state and written in the next through the
// shared index stepper, using the single store port pair. the store needs no
// clearing after reset; only values from written entries are ever used.

module array_list_insert_remove_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  ailr_pkg::req_type req_data,
   output logic              busy,
   output logic              rsp_valid,
   output ailr_pkg::rsp_type rsp_data
);

   ailr_pkg::mem_cmd_type       mem_cmd;
   logic [ailr_pkg::WORD_W-1:0] rd_data;
   logic                        seq_done;
   ailr_pkg::rsp_type           seq_result;

   // response register
   logic              rsp_valid_ff, rsp_valid_in;
   ailr_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // list store, one write and one registered read per cycle
   ailr_mem u_mem (
      .clock   (clock),
      .cmd     (mem_cmd),
      .rd_data (rd_data)
   );

   // sequencer: decodes the request and walks the entries to shift
   ailr_seq u_seq (
      .clock   (clock),
      .reset   (reset),
      .start   (start),
      .req     (req_data),
      .busy    (busy),
      .mem_cmd (mem_cmd),
      .rd_data (rd_data),
      .done    (seq_done),
      .result  (seq_result)
   );

   assign rsp_valid_in = seq_done;
   assign rsp_data_in  = seq_done ? seq_result : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: src/ailr_mem.sv
`timescale 1ns / 1ps

module ailr_mem (
   input  logic                       clock,
   input  ailr_pkg::mem_cmd_type      cmd,
   output logic [ailr_pkg::WORD_W-1:0] rd_data
);

   logic [ailr_pkg::WORD_W-1:0] store_ff [ailr_pkg::DEPTH];
   logic [ailr_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (cmd.we) begin
         store_ff[cmd.waddr] <= cmd.wdata;
      end
      rd_data_ff <= store_ff[cmd.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: src/ailr_seq.sv
`timescale 1ns / 1ps

module ailr_seq (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  ailr_pkg::req_type           req,
   output logic                        busy,
   output ailr_pkg::mem_cmd_type       mem_cmd,
   input  logic [ailr_pkg::WORD_W-1:0] rd_data,
   output logic                        done,
   output ailr_pkg::rsp_type           result
);

   localparam int CW = ailr_pkg::CNT_W;
   localparam int AW = ailr_pkg::ADDR_W;
   localparam int WW = ailr_pkg::WORD_W;

   ailr_pkg::state_type state_ff, state_in;

   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] lim_ff, lim_in;
   logic          dir_up_ff, dir_up_in;
   logic          front_ff, front_in;
   logic          inc_ff, inc_in;
   logic          dec_ff, dec_in;
   logic [WW-1:0] val_ff, val_in;
   logic [WW-1:0] popped_ff, popped_in;
   logic [1:0]    status_ff, status_in;

   logic          accept;
   logic          full;
   logic          empty;
   logic [CW-1:0] idx_step;
   logic [CW-1:0] count_nx;

   assign accept = start && (state_ff == ailr_pkg::S_IDLE);
   assign full   = (count_ff == ailr_pkg::DEPTH_CNT);
   assign empty  = (count_ff == '0);

   // shared index stepper: one position toward the front or the back
   assign idx_step = dir_up_ff ? (idx_ff + CW'(1)) : (idx_ff - CW'(1));

   assign count_nx = inc_ff ? (count_ff + CW'(1)) :
                     dec_ff ? (count_ff - CW'(1)) : count_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ailr_pkg::S_IDLE: begin
            if (accept) begin
               case (req.op)
                  ailr_pkg::OP_PUSH_BACK: begin
                     state_in = full ? ailr_pkg::S_FINISH : ailr_pkg::S_PLACE;
                  end
                  ailr_pkg::OP_PUSH_FRONT: begin
                     if (full) begin
                        state_in = ailr_pkg::S_FINISH;
                     end else if (empty) begin
                        state_in = ailr_pkg::S_PLACE;
                     end else begin
                        state_in = ailr_pkg::S_SHIFT_RD;
                     end
                  end
                  ailr_pkg::OP_INSERT: begin
                     if (full || (req.position > count_ff)) begin
                        state_in = ailr_pkg::S_FINISH;
                     end else if (req.position == count_ff) begin
                        state_in = ailr_pkg::S_PLACE;
                     end else begin
                        state_in = ailr_pkg::S_SHIFT_RD;
                     end
                  end
                  ailr_pkg::OP_POP_BACK, ailr_pkg::OP_POP_FRONT: begin
                     state_in = empty ? ailr_pkg::S_FINISH : ailr_pkg::S_POP_RD;
                  end
                  default: begin
                     state_in = ailr_pkg::S_FINISH;
                  end
               endcase
            end
         end
         ailr_pkg::S_POP_RD: begin
            state_in = ailr_pkg::S_POP_CAP;
         end
         ailr_pkg::S_POP_CAP: begin
            if (front_ff && (lim_ff != '0)) begin
               state_in = ailr_pkg::S_SHIFT_RD;
            end else begin
               state_in = ailr_pkg::S_FINISH;
            end
         end
         ailr_pkg::S_SHIFT_RD: begin
            state_in = ailr_pkg::S_SHIFT_WR;
         end
         ailr_pkg::S_SHIFT_WR: begin
            if (idx_step == lim_ff) begin
               state_in = dir_up_ff ? ailr_pkg::S_FINISH : ailr_pkg::S_PLACE;
            end else begin
               state_in = ailr_pkg::S_SHIFT_RD;
            end
         end
         ailr_pkg::S_PLACE: begin
            state_in = ailr_pkg::S_FINISH;
         end
         ailr_pkg::S_FINISH: begin
            state_in = ailr_pkg::S_IDLE;
         end
         default: begin
            state_in = ailr_pkg::S_IDLE;
         end
      endcase
   end

   // outputs
   always_comb begin
      mem_cmd.we    = 1'b0;
      mem_cmd.waddr = idx_ff[AW-1:0];
      mem_cmd.wdata = rd_data;
      mem_cmd.raddr = idx_step[AW-1:0];
      done          = 1'b0;
      case (state_ff)
         ailr_pkg::S_POP_RD: begin
            mem_cmd.raddr = idx_ff[AW-1:0];
         end
         ailr_pkg::S_SHIFT_WR: begin
            mem_cmd.we = 1'b1;
         end
         ailr_pkg::S_PLACE: begin
            mem_cmd.we    = 1'b1;
            mem_cmd.wdata = val_ff;
         end
         ailr_pkg::S_FINISH: begin
            done = 1'b1;
         end
         default: begin
            mem_cmd.we = 1'b0;
         end
      endcase
   end

   assign busy                = (state_ff != ailr_pkg::S_IDLE);
   assign result.popped_value = popped_ff;
   assign result.status       = status_ff;
   assign result.entry_count  = count_nx;
   assign result.is_empty     = (count_nx == '0);

   // datapath registers
   always_comb begin
      count_in  = count_ff;
      idx_in    = idx_ff;
      lim_in    = lim_ff;
      dir_up_in = dir_up_ff;
      front_in  = front_ff;
      inc_in    = inc_ff;
      dec_in    = dec_ff;
      val_in    = val_ff;
      popped_in = popped_ff;
      status_in = status_ff;
      case (state_ff)
         ailr_pkg::S_IDLE: begin
            if (accept) begin
               val_in    = req.value;
               popped_in = '0;
               status_in = ailr_pkg::STAT_DONE;
               inc_in    = 1'b0;
               dec_in    = 1'b0;
               dir_up_in = 1'b0;
               front_in  = 1'b0;
               idx_in    = count_ff;
               lim_in    = count_ff;
               case (req.op)
                  ailr_pkg::OP_PUSH_BACK: begin
                     if (full) status_in = ailr_pkg::STAT_FULL;
                     else inc_in = 1'b1;
                  end
                  ailr_pkg::OP_PUSH_FRONT: begin
                     lim_in = '0;
                     if (full) status_in = ailr_pkg::STAT_FULL;
                     else inc_in = 1'b1;
                  end
                  ailr_pkg::OP_INSERT: begin
                     lim_in = CW'(req.position);
                     if (full) status_in = ailr_pkg::STAT_FULL;
                     else if (req.position > count_ff) status_in = ailr_pkg::STAT_BADPOS;
                     else inc_in = 1'b1;
                  end
                  ailr_pkg::OP_POP_BACK: begin
                     idx_in = count_ff - CW'(1);
                     if (empty) status_in = ailr_pkg::STAT_EMPTY;
                     else dec_in = 1'b1;
                  end
                  ailr_pkg::OP_POP_FRONT: begin
                     idx_in    = '0;
                     lim_in    = count_ff - CW'(1);
                     front_in  = 1'b1;
                     dir_up_in = 1'b1;
                     if (empty) status_in = ailr_pkg::STAT_EMPTY;
                     else dec_in = 1'b1;
                  end
                  default: begin
                     status_in = ailr_pkg::STAT_DONE;
                  end
               endcase
            end
         end
         ailr_pkg::S_POP_CAP: begin
            popped_in = rd_data;
         end
         ailr_pkg::S_SHIFT_WR: begin
            idx_in = idx_step;
         end
         ailr_pkg::S_FINISH: begin
            count_in = count_nx;
         end
         default: begin
            idx_in = idx_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ailr_pkg::S_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
      idx_ff    <= idx_in;
      lim_ff    <= lim_in;
      dir_up_ff <= dir_up_in;
      front_ff  <= front_in;
      inc_ff    <= inc_in;
      dec_ff    <= dec_in;
      val_ff    <= val_in;
      popped_ff <= popped_in;
      status_ff <= status_in;
   end

endmodule
